@@ sv/bci_pkg.sv @@
package bci_pkg;

  // Field widths
  localparam int unsigned CoordW  = 16;
  localparam int unsigned ValW    = 16;
  localparam int unsigned CountW  = 3;
  localparam int unsigned Corners = 4;

  // Accumulator widths: a corner pair sum fits 32 bits, the full numerator 48 bits
  localparam int unsigned PairW = 32;
  localparam int unsigned NumW  = 48;
  localparam int unsigned DenW  = 32;

  // Operation codes carried in tuser
  localparam logic [1:0] FUNC_QRY_STORED = 2'd0;
  localparam logic [1:0] FUNC_QRY_GIVEN  = 2'd1;
  localparam logic [1:0] FUNC_LOAD       = 2'd2;
  localparam logic [1:0] FUNC_STEP       = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_LEFT_X   = 2'd0;
  localparam logic [1:0] REG_RIGHT_X  = 2'd1;
  localparam logic [1:0] REG_BOTTOM_Y = 2'd2;
  localparam logic [1:0] REG_TOP_Y    = 2'd3;

  localparam logic [CoordW-1:0] LEFT_X_RST   = 16'd0;
  localparam logic [CoordW-1:0] RIGHT_X_RST  = 16'd255;
  localparam logic [CoordW-1:0] BOTTOM_Y_RST = 16'd0;
  localparam logic [CoordW-1:0] TOP_Y_RST    = 16'd255;

  // Multiply sequence: one product per step into the named accumulator
  localparam logic [2:0] MS_LO_FIRST  = 3'd0;  // lo  = bx * ll
  localparam logic [2:0] MS_LO_ACC    = 3'd1;  // lo += ax * rl
  localparam logic [2:0] MS_UP_FIRST  = 3'd2;  // up  = bx * lh
  localparam logic [2:0] MS_UP_ACC    = 3'd3;  // up += ax * rh
  localparam logic [2:0] MS_NUM_FIRST = 3'd4;  // num  = by * lo
  localparam logic [2:0] MS_NUM_ACC   = 3'd5;  // num += ay * up
  localparam logic [2:0] MS_DEN       = 3'd6;  // den  = dx * dy

  // Divider: the rounded quotient always fits the value width
  localparam int unsigned DivSteps = ValW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  typedef struct packed {
    logic [CoordW-1:0] left_x;
    logic [CoordW-1:0] right_x;
    logic [CoordW-1:0] bottom_y;
    logic [CoordW-1:0] top_y;
  } cfg_t;

  typedef struct packed {
    logic       capture;
    logic       update;
    logic       setup;
    logic       mul_en;
    logic [2:0] mul_sel;
    logic       div_init;
    logic       div_step;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic degenerate;
    logic out_busy;
  } sts_t;

endpackage

@@ sv/bci_ctrl.sv @@
module bci_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  output logic          s_ready_o,
  input  bci_pkg::sts_t sts_i,
  output bci_pkg::cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_SETUP  = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_DIVI   = 3'd4;
  localparam logic [2:0] ST_DIV    = 3'd5;
  localparam logic [2:0] ST_FIN    = 3'd6;

  logic [2:0]                  state_q, state_d;
  logic [2:0]                  mul_cnt_q, mul_cnt_d;
  logic [bci_pkg::DivCntW-1:0] div_cnt_q, div_cnt_d;

  // Queries on a non-degenerate rectangle: decode, setup, multiply, divide, result load; all else: decode, result load
  always_comb begin
    state_d   = state_q;
    mul_cnt_d = mul_cnt_q;
    div_cnt_d = div_cnt_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts_i.is_query && !sts_i.degenerate) begin
          state_d = ST_SETUP;
        end else begin
          cmd_o.update = !sts_i.is_query;
          state_d      = ST_FIN;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        mul_cnt_d   = bci_pkg::MS_LO_FIRST;
        state_d     = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = mul_cnt_q;
        if (mul_cnt_q == bci_pkg::MS_DEN) begin
          state_d = ST_DIVI;
        end else begin
          mul_cnt_d = mul_cnt_q + 3'd1;
        end
      end
      ST_DIVI: begin
        cmd_o.div_init = 1'b1;
        div_cnt_d      = '0;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (div_cnt_q == bci_pkg::DivCntW'(bci_pkg::DivSteps - 1)) begin
          state_d = ST_FIN;
        end else begin
          div_cnt_d = div_cnt_q + 1'b1;
        end
      end
      ST_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      mul_cnt_q <= '0;
      div_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      mul_cnt_q <= mul_cnt_d;
      div_cnt_q <= div_cnt_d;
    end
  end

  // A result load always returns the sequencer to idle
  a_load_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> (state_q == ST_IDLE))
    else $error("sequencer not idle after result load");

  // Divide starts only after the last multiply step
  a_div_after_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVI) |-> $past(state_q == ST_MUL && mul_cnt_q == bci_pkg::MS_DEN))
    else $error("divider started before multiply sequence finished");

endmodule

@@ sv/bci_dp.sv @@
module bci_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bci_pkg::cfg_t        cfg_i,
  input  logic [95:0]          s_tdata_i,
  input  logic [1:0]           s_tuser_i,
  input  bci_pkg::cmd_t        cmd_i,
  output bci_pkg::sts_t        sts_o,
  input  logic                 m_tready_i,
  output logic                 m_tvalid_o,
  output logic [23:0]          m_tdata_o
);

  localparam int unsigned CW = bci_pkg::CoordW;
  localparam int unsigned VW = bci_pkg::ValW;

  logic [1:0]                 func_q;
  logic [CW-1:0]              px_q, py_q;
  logic [VW-1:0]              c_q [bci_pkg::Corners];
  logic [VW-1:0]              corner_q [bci_pkg::Corners];
  logic [CW-1:0]              ax_q, bx_q, ay_q, by_q, dx_q, dy_q;
  logic [bci_pkg::PairW-1:0]  lo_q, up_q;
  logic [bci_pkg::NumW-1:0]   num_q;
  logic [bci_pkg::DenW-1:0]   den_q;
  logic [bci_pkg::DenW:0]     rem_q;
  logic [VW-1:0]              nlo_q, quo_q;
  logic [bci_pkg::CountW-1:0] moved_q;
  logic                       out_valid_q;
  logic [23:0]                out_data_q;

  logic                       is_query, degenerate;
  logic [CW-1:0]              xc, yc;
  logic [CW-1:0]              mul_a;
  logic [bci_pkg::PairW-1:0]  mul_b;
  logic [bci_pkg::NumW-1:0]   prod;
  logic [bci_pkg::NumW+1:0]   dividend;
  logic [bci_pkg::DenW:0]     dsor;
  logic [bci_pkg::DenW+1:0]   trial;
  logic                       q_bit;
  logic [bci_pkg::Corners-1:0] up_mv, dn_mv;
  logic [bci_pkg::CountW-1:0] moved_d;
  logic [VW-1:0]              val_d;

  assign is_query   = !func_q[1];
  assign degenerate = (cfg_i.right_x <= cfg_i.left_x) || (cfg_i.top_y <= cfg_i.bottom_y);

  assign sts_o.is_query   = is_query;
  assign sts_o.degenerate = degenerate;
  assign sts_o.out_busy   = out_valid_q && !m_tready_i;

  // Clamp the point into the rectangle
  always_comb begin
    if (px_q < cfg_i.left_x)       xc = cfg_i.left_x;
    else if (px_q > cfg_i.right_x) xc = cfg_i.right_x;
    else                           xc = px_q;
    if (py_q < cfg_i.bottom_y)     yc = cfg_i.bottom_y;
    else if (py_q > cfg_i.top_y)   yc = cfg_i.top_y;
    else                           yc = py_q;
  end

  // Select multiplier operands for the current step
  always_comb begin
    case (cmd_i.mul_sel)
      bci_pkg::MS_LO_FIRST:  begin mul_a = bx_q; mul_b = 32'(c_q[0]); end
      bci_pkg::MS_LO_ACC:    begin mul_a = ax_q; mul_b = 32'(c_q[2]); end
      bci_pkg::MS_UP_FIRST:  begin mul_a = bx_q; mul_b = 32'(c_q[1]); end
      bci_pkg::MS_UP_ACC:    begin mul_a = ax_q; mul_b = 32'(c_q[3]); end
      bci_pkg::MS_NUM_FIRST: begin mul_a = by_q; mul_b = lo_q; end
      bci_pkg::MS_NUM_ACC:   begin mul_a = ay_q; mul_b = up_q; end
      bci_pkg::MS_DEN:       begin mul_a = dx_q; mul_b = 32'(dy_q); end
      default:               begin mul_a = '0;   mul_b = '0; end
    endcase
  end

  assign prod = 48'(mul_a) * 48'(mul_b);

  // Rounded quotient: floor((2*num + den) / (2*den)), one bit per step
  assign dividend = {1'b0, num_q, 1'b0} + 50'(den_q);
  assign dsor     = {den_q, 1'b0};
  assign trial    = {rem_q, nlo_q[VW-1]};
  assign q_bit    = trial >= {1'b0, dsor};

  // Step each stored corner toward its target
  always_comb begin
    for (int i = 0; i < bci_pkg::Corners; i++) begin
      up_mv[i] = c_q[i] > corner_q[i];
      dn_mv[i] = c_q[i] < corner_q[i];
    end
    moved_d = 3'(up_mv[0] | dn_mv[0]) + 3'(up_mv[1] | dn_mv[1])
            + 3'(up_mv[2] | dn_mv[2]) + 3'(up_mv[3] | dn_mv[3]);
  end

  assign val_d = (is_query && !degenerate) ? quo_q : '0;

  // Capture item and run the arithmetic
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q  <= s_tuser_i;
      px_q    <= s_tdata_i[15:0];
      py_q    <= s_tdata_i[31:16];
      for (int i = 0; i < bci_pkg::Corners; i++) begin
        c_q[i] <= (s_tuser_i == bci_pkg::FUNC_QRY_STORED) ?
                  corner_q[i] : s_tdata_i[32 + 16*i +: 16];
      end
    end
    if (cmd_i.setup) begin
      ax_q <= xc - cfg_i.left_x;
      bx_q <= cfg_i.right_x - xc;
      ay_q <= yc - cfg_i.bottom_y;
      by_q <= cfg_i.top_y - yc;
      dx_q <= cfg_i.right_x - cfg_i.left_x;
      dy_q <= cfg_i.top_y - cfg_i.bottom_y;
    end
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_sel)
        bci_pkg::MS_LO_FIRST:  lo_q  <= prod[31:0];
        bci_pkg::MS_LO_ACC:    lo_q  <= lo_q + prod[31:0];
        bci_pkg::MS_UP_FIRST:  up_q  <= prod[31:0];
        bci_pkg::MS_UP_ACC:    up_q  <= up_q + prod[31:0];
        bci_pkg::MS_NUM_FIRST: num_q <= prod;
        bci_pkg::MS_NUM_ACC:   num_q <= num_q + prod;
        bci_pkg::MS_DEN:       den_q <= prod[31:0];
        default: ;
      endcase
    end
    if (cmd_i.div_init) begin
      rem_q <= dividend[48:16];
      nlo_q <= dividend[15:0];
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= q_bit ? 33'(trial - {1'b0, dsor}) : trial[32:0];
      nlo_q <= {nlo_q[VW-2:0], 1'b0};
      quo_q <= {quo_q[VW-2:0], q_bit};
    end
  end

  // Stored corners, step count and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bci_pkg::Corners; i++) corner_q[i] <= '0;
      moved_q     <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (cmd_i.capture) begin
        moved_q <= '0;
      end else if (cmd_i.update) begin
        if (func_q == bci_pkg::FUNC_LOAD) begin
          for (int i = 0; i < bci_pkg::Corners; i++) corner_q[i] <= c_q[i];
        end else begin
          for (int i = 0; i < bci_pkg::Corners; i++) begin
            if (up_mv[i])      corner_q[i] <= corner_q[i] + 1'b1;
            else if (dn_mv[i]) corner_q[i] <= corner_q[i] - 1'b1;
          end
          moved_q <= moved_d;
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
        out_data_q  <= {4'b0, is_query && degenerate, moved_q, val_d};
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;

  // Never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || m_tready_i))
    else $error("result register overwritten");

  // A query on a degenerate rectangle reports the flag and a zero value
  a_degenerate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && is_query && degenerate) |=>
      (m_tvalid_o && m_tdata_o[19] && (m_tdata_o[15:0] == 16'd0)))
    else $error("degenerate query result wrong");

  // Partial remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (rem_q < dsor))
    else $error("divider remainder out of range");

endmodule

@@ sv/bilinear_corner_interpolator.sv @@
// Bilinear interpolation over a rectangle set by four config registers, with four
// stored 16-bit corner values. tuser carries the operation (0 query stored corners,
// 1 query the item's corners, 2 load corners, 3 step stored corners one unit toward
// the item's corners). One item is worked at a time and gives one result. A query
// goes from acceptance to the result register through decode, setup, seven
// steps of one shared 16x32 multiplier, a divider load, sixteen steps of a
// bit-serial divider for the rounded quotient and the result load. Load, step and
// queries on a degenerate rectangle go through decode and result load only. The
// result load waits while an earlier result still sits untaken in the output
// register. The next item is accepted from the cycle after the result load, even
// while the result still waits to be taken.
module bilinear_corner_interpolator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // point_x, point_y, corner_ll, corner_lh, corner_rl, corner_rh
  input  logic [95:0] s_axis_tdata,
  // func
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // point_value, moved_count, bad_setup, zero fill
  output logic [23:0] m_axis_tdata
);

  bci_pkg::cfg_t cfg_q;
  bci_pkg::cmd_t cmd;
  bci_pkg::sts_t sts;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left_x   <= bci_pkg::LEFT_X_RST;
      cfg_q.right_x  <= bci_pkg::RIGHT_X_RST;
      cfg_q.bottom_y <= bci_pkg::BOTTOM_Y_RST;
      cfg_q.top_y    <= bci_pkg::TOP_Y_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bci_pkg::REG_LEFT_X:   cfg_q.left_x   <= cfg_wdata_i;
        bci_pkg::REG_RIGHT_X:  cfg_q.right_x  <= cfg_wdata_i;
        bci_pkg::REG_BOTTOM_Y: cfg_q.bottom_y <= cfg_wdata_i;
        bci_pkg::REG_TOP_Y:    cfg_q.top_y    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  bci_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  bci_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tdata_o  (m_axis_tdata)
  );

endmodule

@@ bench/tb_bilinear_corner_interpolator.sv @@
`timescale 1ns / 100ps

module tb_bilinear_corner_interpolator;

  localparam int unsigned ResetCycles    = 7;
  localparam int unsigned RandomItems    = 1000;
  localparam int unsigned RandomPhases   = 8;
  localparam int unsigned BurstItems     = 40;
  localparam int unsigned LongHoldCycles = 300;
  localparam int unsigned DrainCycles    = 40;
  localparam int unsigned TimeoutNs      = 4_000_000;

  // Input item: func travels in tuser, the rest in tdata
  typedef struct packed {
    logic [1:0]                                   func;
    logic [bci_pkg::Corners-1:0][bci_pkg::ValW-1:0] corners;  // [0] ll, [1] lh, [2] rl, [3] rh
    logic [bci_pkg::CoordW-1:0]                   py;
    logic [bci_pkg::CoordW-1:0]                   px;
  } bci_item_t;

  // Result item, laid out as the low bits of m_axis_tdata
  typedef struct packed {
    logic                       bad;
    logic [bci_pkg::CountW-1:0] moved;
    logic [bci_pkg::ValW-1:0]   value;
  } bci_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;   // point_x, point_y, corner_ll, corner_lh, corner_rl, corner_rh
  logic [1:0]  s_axis_tuser;   // func
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // point_value, moved_count, bad_setup, zero fill

  // Shadow of the rectangle and of the stored corners
  logic [bci_pkg::CoordW-1:0] rect_left   = bci_pkg::LEFT_X_RST;
  logic [bci_pkg::CoordW-1:0] rect_right  = bci_pkg::RIGHT_X_RST;
  logic [bci_pkg::CoordW-1:0] rect_bottom = bci_pkg::BOTTOM_Y_RST;
  logic [bci_pkg::CoordW-1:0] rect_top    = bci_pkg::TOP_Y_RST;
  logic [bci_pkg::ValW-1:0]   corner_mem [bci_pkg::Corners] = '{default: '0};

  bci_result_t pending_results [$];
  int unsigned error_count = 0;
  bit          idle_on     = 1'b1;
  int unsigned hold_req    = 0;
  int unsigned hold_seen   = 0;

  bilinear_corner_interpolator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Rounded bilinear value over the shadow rectangle; flag a degenerate one
  function automatic logic [bci_pkg::ValW-1:0] interp_value(
      input logic [bci_pkg::CoordW-1:0] px, py,
      input logic [bci_pkg::Corners-1:0][bci_pkg::ValW-1:0] c,
      output logic bad);
    longint unsigned lx, rx, by0, ty, x, y, ax, bx, ay, by, lower, upper, num, den;
    lx  = rect_left;
    rx  = rect_right;
    by0 = rect_bottom;
    ty  = rect_top;
    if (rx <= lx || ty <= by0) begin
      bad = 1'b1;
      return '0;
    end
    bad = 1'b0;
    x = (px < lx) ? lx : (px > rx) ? rx : px;
    y = (py < by0) ? by0 : (py > ty) ? ty : py;
    ax = x - lx;
    bx = rx - x;
    ay = y - by0;
    by = ty - y;
    lower = bx * c[0] + ax * c[2];
    upper = bx * c[1] + ax * c[3];
    num   = by * lower + ay * upper;
    den   = (rx - lx) * (ty - by0);
    return bci_pkg::ValW'((2 * num + den) / (2 * den));
  endfunction

  // Work out the result of one accepted item and advance the stored corners
  function automatic bci_result_t predict_result(input bci_item_t it);
    bci_result_t                                    r;
    logic [bci_pkg::Corners-1:0][bci_pkg::ValW-1:0] held;
    logic                                           bad;
    r = '0;
    case (it.func)
      bci_pkg::FUNC_QRY_STORED: begin
        for (int i = 0; i < bci_pkg::Corners; i++) held[i] = corner_mem[i];
        r.value = interp_value(it.px, it.py, held, bad);
        r.bad   = bad;
      end
      bci_pkg::FUNC_QRY_GIVEN: begin
        r.value = interp_value(it.px, it.py, it.corners, bad);
        r.bad   = bad;
      end
      bci_pkg::FUNC_LOAD: begin
        for (int i = 0; i < bci_pkg::Corners; i++) corner_mem[i] = it.corners[i];
      end
      bci_pkg::FUNC_STEP: begin
        for (int i = 0; i < bci_pkg::Corners; i++) begin
          if (it.corners[i] > corner_mem[i]) begin
            corner_mem[i] = corner_mem[i] + 1'b1;
            r.moved++;
          end else if (it.corners[i] < corner_mem[i]) begin
            corner_mem[i] = corner_mem[i] - 1'b1;
            r.moved++;
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic bci_item_t item_of(input logic [1:0] func,
                                        input logic [15:0] px, py, ll, lh, rl, rh);
    bci_item_t it;
    it.func    = func;
    it.px      = px;
    it.py      = py;
    it.corners = {rh, rl, lh, ll};
    return it;
  endfunction

  // Mostly inside the span, sometimes anywhere
  function automatic logic [15:0] rand_coord(input logic [15:0] lo, hi);
    if ($urandom_range(0, 99) < 80) return 16'($urandom_range(lo, hi));
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [15:0] rand_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'd0;
    if (r < 20) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic bci_item_t make_random_item();
    bci_item_t   it;
    int unsigned k;
    int          t;
    k = $urandom_range(0, 99);
    it.func = (k < 30) ? bci_pkg::FUNC_QRY_STORED :
              (k < 55) ? bci_pkg::FUNC_QRY_GIVEN :
              (k < 65) ? bci_pkg::FUNC_LOAD : bci_pkg::FUNC_STEP;
    it.px = rand_coord(rect_left, rect_right);
    it.py = rand_coord(rect_bottom, rect_top);
    for (int i = 0; i < bci_pkg::Corners; i++) begin
      k = $urandom_range(0, 99);
      if (it.func == bci_pkg::FUNC_STEP && k < 50) begin
        // target close to the stored corner, so it sometimes lands on it
        t = int'(corner_mem[i]) + int'($urandom_range(0, 4)) - 2;
        t = (t < 0) ? 0 : (t > 65535) ? 65535 : t;
        it.corners[i] = 16'(t);
      end else if (it.func == bci_pkg::FUNC_STEP && k < 70) begin
        it.corners[i] = corner_mem[i];
      end else begin
        it.corners[i] = rand_value();
      end
    end
    return it;
  endfunction

  function automatic int unsigned tx_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one item, wait for acceptance, queue its expected result
  task automatic send_item(input bci_item_t it);
    int unsigned gap;
    gap = tx_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {it.corners, it.py, it.px};
    s_axis_tuser  <= it.func;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(predict_result(it));
  endtask

  // Drop valid and wait until every queued result has come back
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
  endtask

  // Rewrite the left, right, bottom and top edges while the block is idle
  task automatic set_rect(input logic [15:0] l, r, b, t);
    wait_drain();
    cfg_write(bci_pkg::REG_LEFT_X, l);
    cfg_write(bci_pkg::REG_RIGHT_X, r);
    cfg_write(bci_pkg::REG_BOTTOM_Y, b);
    cfg_write(bci_pkg::REG_TOP_Y, t);
    cfg_we_i    <= 1'b0;
    rect_left   = l;
    rect_right  = r;
    rect_bottom = b;
    rect_top    = t;
  endtask

  // Reset rectangle: corners, clamping, extremes of values, every kind of step
  task automatic test_directed();
    send_item(item_of(bci_pkg::FUNC_QRY_STORED, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
    send_item(item_of(bci_pkg::FUNC_LOAD, 16'd0, 16'd0,
                      16'd1000, 16'd2000, 16'd3000, 16'd4000));
    send_item(item_of(bci_pkg::FUNC_QRY_STORED, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
    send_item(item_of(bci_pkg::FUNC_QRY_STORED, 16'd255, 16'd255,
                      16'd0, 16'd0, 16'd0, 16'd0));
    send_item(item_of(bci_pkg::FUNC_QRY_STORED, 16'd128, 16'd64,
                      16'd0, 16'd0, 16'd0, 16'd0));
    send_item(item_of(bci_pkg::FUNC_QRY_STORED, 16'hFFFF, 16'hFFFF,
                      16'd0, 16'd0, 16'd0, 16'd0));
    send_item(item_of(bci_pkg::FUNC_QRY_STORED, 16'hFFFF, 16'd0,
                      16'd0, 16'd0, 16'd0, 16'd0));
    send_item(item_of(bci_pkg::FUNC_QRY_GIVEN, 16'd17, 16'd200,
                      16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(item_of(bci_pkg::FUNC_QRY_GIVEN, 16'hFFFF, 16'hFFFF,
                      16'd0, 16'd0, 16'd0, 16'd0));
    send_item(item_of(bci_pkg::FUNC_QRY_GIVEN, 16'd1, 16'd1,
                      16'hFFFF, 16'd0, 16'd0, 16'd0));
    // step: all at target, then a mix of up, down and held
    send_item(item_of(bci_pkg::FUNC_STEP, 16'd0, 16'd0,
                      16'd1000, 16'd2000, 16'd3000, 16'd4000));
    send_item(item_of(bci_pkg::FUNC_STEP, 16'd0, 16'd0,
                      16'd1001, 16'd0, 16'd3000, 16'hFFFF));
    send_item(item_of(bci_pkg::FUNC_QRY_STORED, 16'd100, 16'd200,
                      16'd0, 16'd0, 16'd0, 16'd0));
    send_item(item_of(bci_pkg::FUNC_LOAD, 16'd0, 16'd0,
                      16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(item_of(bci_pkg::FUNC_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
    send_item(item_of(bci_pkg::FUNC_QRY_STORED, 16'd128, 16'd128,
                      16'd0, 16'd0, 16'd0, 16'd0));
    send_item(item_of(bci_pkg::FUNC_LOAD, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
    send_item(item_of(bci_pkg::FUNC_STEP, 16'd0, 16'd0,
                      16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(item_of(bci_pkg::FUNC_QRY_STORED, 16'd255, 16'd0,
                      16'd0, 16'd0, 16'd0, 16'd0));
  endtask

  // Quotients that land exactly on one half round up
  task automatic test_half_rounding();
    set_rect(16'd0, 16'd2, 16'd0, 16'd1);
    send_item(item_of(bci_pkg::FUNC_QRY_GIVEN, 16'd1, 16'd0, 16'd0, 16'd0, 16'd1, 16'd1));
    send_item(item_of(bci_pkg::FUNC_QRY_GIVEN, 16'd1, 16'd0, 16'd0, 16'd0, 16'd3, 16'd3));
  endtask

  // Zero or negative width and zero or negative height: queries flag, the rest is unaffected
  task automatic test_degenerate();
    set_rect(16'd100, 16'd100, 16'd0, 16'd255);
    send_item(item_of(bci_pkg::FUNC_QRY_STORED, 16'd100, 16'd10,
                      16'd0, 16'd0, 16'd0, 16'd0));
    send_item(item_of(bci_pkg::FUNC_QRY_GIVEN, 16'd100, 16'd10,
                      16'd9, 16'd9, 16'd9, 16'd9));
    send_item(item_of(bci_pkg::FUNC_LOAD, 16'd0, 16'd0, 16'd5, 16'd6, 16'd7, 16'd8));
    send_item(item_of(bci_pkg::FUNC_STEP, 16'd0, 16'd0, 16'd6, 16'd6, 16'd6, 16'd6));
    set_rect(16'd0, 16'd255, 16'd200, 16'd100);
    send_item(item_of(bci_pkg::FUNC_QRY_STORED, 16'd50, 16'd150,
                      16'd0, 16'd0, 16'd0, 16'd0));
    send_item(item_of(bci_pkg::FUNC_QRY_GIVEN, 16'd50, 16'd150,
                      16'd1, 16'd2, 16'd3, 16'd4));
    set_rect(16'd300, 16'd200, 16'd7, 16'd7);
    send_item(item_of(bci_pkg::FUNC_QRY_GIVEN, 16'd250, 16'd7,
                      16'd1, 16'd2, 16'd3, 16'd4));
  endtask

  // Random traffic over a series of rectangles, extremes and degenerate ones included
  task automatic test_random_traffic();
    int unsigned l, b;
    for (int ph = 0; ph < RandomPhases; ph++) begin
      l = $urandom_range(0, 65000);
      b = $urandom_range(0, 65000);
      case (ph)
        0: set_rect(16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
        1: set_rect(16'hFFFE, 16'hFFFF, 16'd0, 16'd1);
        2: set_rect(16'(l), 16'(l + $urandom_range(1, 300)),
                    16'(b), 16'(b + $urandom_range(1, 300)));
        3: set_rect(16'(l), 16'($urandom_range(0, l)), 16'd0, 16'd255);
        4: set_rect(16'd0, 16'd1000, 16'd500, 16'd500);
        default: set_rect(16'(l), 16'($urandom_range(l + 1, 65535)),
                          16'(b), 16'($urandom_range(b + 1, 65535)));
      endcase
      idle_on = (ph % 3 != 2);
      repeat (RandomItems / RandomPhases) send_item(make_random_item());
    end
    idle_on = 1'b1;
  endtask

  // Receiver holds off for a long stretch while items keep coming back to back
  task automatic test_backpressure();
    set_rect(16'd10, 16'd1010, 16'd20, 16'd520);
    idle_on = 1'b0;
    hold_req++;
    repeat (BurstItems) send_item(make_random_item());
    idle_on = 1'b1;
  endtask

  // Result side: random ready gaps, plus the long hold on request
  initial begin : rx_side
    int unsigned gap;
    gap = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        gap = LongHoldCycles;
      end else if (gap == 0 && idle_on && $urandom_range(0, 3) == 0) begin
        gap = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3) : $urandom_range(10, 50);
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        gap--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Compare each result taken with the oldest expectation
  always @(posedge clk_i) begin : result_check
    bci_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = bci_result_t'(m_axis_tdata[19:0]);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result value=%0d moved=%0d bad=%0d",
                 $time, got.value, got.moved, got.bad);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          $display("%0t: expected value=%0d moved=%0d bad=%0d got value=%0d moved=%0d bad=%0d",
                   $time, want.value, want.moved, want.bad, got.value, got.moved, got.bad);
          error_count++;
        end
      end
    end
  end

  initial begin : main_seq
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= bci_pkg::REG_LEFT_X;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= bci_pkg::FUNC_QRY_STORED;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_half_rounding();
    test_degenerate();
    test_random_traffic();
    test_backpressure();

    wait_drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_bilinear_corner_interpolator: done, clean");
    end else begin
      $display("tb_bilinear_corner_interpolator: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeoutNs);
    $display("%0t: timeout", $time);
    $display("tb_bilinear_corner_interpolator: done, errors");
    $finish;
  end

endmodule
